[rtl/egbw_pkg.sv]
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types, field widths, kind codes and helpers for the Exp-Golomb
// bitstream writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package egbw_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NBITS_W  = 6;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_RAW   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALIGN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;

  localparam logic [COUNT_W-1:0] RAW_MAX = 6'd32;

  typedef enum logic [1:0] {
    OP_BITS,
    OP_ALIGN,
    OP_FLUSH,
    OP_NONE
  } egbw_op_e;

  // Bit string of nbits, right-aligned in word; the packer masks off any bits above nbits.
  typedef struct packed {
    egbw_op_e             op;
    logic [VALUE_W-1:0]   word;
    logic [NBITS_W-1:0]   nbits;
  } egbw_entry_t;

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [COUNT_W-1:0] egbw_msb_len(input logic [VALUE_W-1:0] w);
    logic [COUNT_W-1:0] len;
    len = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (w[i]) begin
        len = COUNT_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

[rtl/egbw_in_if.sv]
// ----------------------------------------------------------------------------
// egbw_in_if
// Input channel: one syntax element word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface egbw_in_if;
  import egbw_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, kind, value, bit_count, input ready);
  modport sink   (input valid, kind, value, bit_count, output ready);
endinterface

`default_nettype wire

[rtl/egbw_out_if.sv]
// ----------------------------------------------------------------------------
// egbw_out_if
// Output channel: one bitstream byte per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface egbw_out_if;
  import egbw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

[rtl/egbw_front.sv]
// ----------------------------------------------------------------------------
// egbw_front
// Accepts syntax elements, forms the code number and the length of the bit
// string, and pushes one queue entry per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egbw_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  egbw_in_if.sink                   in_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output egbw_pkg::egbw_entry_t     push_entry_o
);
  import egbw_pkg::*;

  logic               fr_valid_q, fr_valid_d;
  egbw_op_e           fr_op_q, fr_op_d;
  logic [VALUE_W-1:0] fr_word_q, fr_word_d;
  logic               fr_eg_q, fr_eg_d;
  logic [COUNT_W-1:0] fr_raw_n_q, fr_raw_n_d;

  logic               load;
  logic [VALUE_W-1:0] neg_value;
  logic               se_positive;
  logic [COUNT_W-1:0] eg_len;
  logic [NBITS_W:0]   eg_nbits;

  assign in_i.ready = !fr_valid_q || push_ready_i;
  assign load       = in_i.valid && in_i.ready;

  assign neg_value   = VALUE_W'(0) - in_i.value;
  assign se_positive = (in_i.value != '0) && !in_i.value[VALUE_W-1];

  always_comb begin
    fr_op_d    = OP_NONE;
    fr_word_d  = in_i.value;
    fr_eg_d    = 1'b0;
    fr_raw_n_d = (in_i.bit_count > RAW_MAX) ? RAW_MAX : in_i.bit_count;
    case (in_i.kind)
      KIND_RAW: begin
        fr_op_d = OP_BITS;
      end
      KIND_UE: begin
        fr_op_d   = OP_BITS;
        fr_eg_d   = 1'b1;
        fr_word_d = in_i.value + VALUE_W'(1);
      end
      KIND_SE: begin
        fr_op_d   = OP_BITS;
        fr_eg_d   = 1'b1;
        fr_word_d = se_positive ? {in_i.value[VALUE_W-2:0], 1'b0}
                                : {neg_value[VALUE_W-2:0], 1'b1};
      end
      KIND_ALIGN: begin
        fr_op_d = OP_ALIGN;
      end
      KIND_FLUSH: begin
        fr_op_d = OP_FLUSH;
      end
      default: begin
        fr_op_d = OP_NONE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      fr_valid_d = 1'b1;
    end else if (push_ready_i) begin
      fr_valid_d = 1'b0;
    end else begin
      fr_valid_d = fr_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_op_q    <= fr_op_d;
      fr_word_q  <= fr_word_d;
      fr_eg_q    <= fr_eg_d;
      fr_raw_n_q <= fr_raw_n_d;
    end
  end

  // ue code: len-1 zeros then the code number, 2*len-1 bits in all.
  assign eg_len   = egbw_msb_len(fr_word_q);
  assign eg_nbits = (eg_len == '0) ? '0 : ({eg_len, 1'b0} - (NBITS_W+1)'(1));

  assign push_valid_o       = fr_valid_q;
  assign push_entry_o.op    = fr_op_q;
  assign push_entry_o.word  = fr_word_q;
  assign push_entry_o.nbits = fr_eg_q ? eg_nbits[NBITS_W-1:0] : NBITS_W'(fr_raw_n_q);

endmodule

`default_nettype wire

[rtl/egbw_queue.sv]
// ----------------------------------------------------------------------------
// egbw_queue
// Short register queue between the front and the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egbw_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire egbw_pkg::egbw_entry_t push_entry_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_i,
  output egbw_pkg::egbw_entry_t     pop_entry_o
);
  import egbw_pkg::*;

  egbw_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop  ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/egbw_back.sv]
// ----------------------------------------------------------------------------
// egbw_back
// Byte packer: merges queue entries into the pending partial byte and emits
// one completed byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egbw_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire egbw_pkg::egbw_entry_t head_i,
  output logic                       pop_o,
  egbw_out_if.source                 out_o
);
  import egbw_pkg::*;

  logic [2:0]          pc_q, pc_d;
  logic [6:0]          pbits_q, pbits_d;
  logic [NBITS_W-1:0]  rem_q, rem_d;
  logic                started_q, started_d;
  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                out_last_q;

  logic [NBITS_W-1:0]  rem;
  logic [3:0]          k;
  logic [NBITS_W:0]    sum;
  logic [NBITS_W-1:0]  sh;
  logic [VALUE_W-1:0]  shifted;
  logic                emit, done, last;
  logic [BYTE_W-1:0]   byte_d;
  logic                can_out, step;

  assign rem     = started_q ? rem_q : head_i.nbits;
  assign k       = 4'd8 - {1'b0, pc_q};
  assign sum     = {4'b0, pc_q} + {1'b0, rem};
  assign sh      = rem - NBITS_W'(k);
  assign shifted = head_i.word >> sh;

  always_comb begin
    emit      = 1'b0;
    done      = 1'b0;
    last      = 1'b0;
    byte_d    = '0;
    pc_d      = pc_q;
    pbits_d   = pbits_q;
    rem_d     = rem_q;
    started_d = started_q;
    case (head_i.op)
      OP_BITS: begin
        if (sum >= (NBITS_W+1)'(8)) begin
          emit   = 1'b1;
          byte_d = BYTE_W'({1'b0, pbits_q} << k) | (shifted[BYTE_W-1:0] & (8'hff >> pc_q));
          last   = (sh < NBITS_W'(8));
          done   = last;
          if (last) begin
            pbits_d = head_i.word[6:0] & (7'h7f >> (3'd7 - sh[2:0]));
            pc_d    = sh[2:0];
          end else begin
            pbits_d   = '0;
            pc_d      = '0;
            rem_d     = sh;
            started_d = 1'b1;
          end
        end else begin
          done    = 1'b1;
          pbits_d = (pbits_q << rem[2:0]) | (head_i.word[6:0] & (7'h7f >> (3'd7 - rem[2:0])));
          pc_d    = pc_q + rem[2:0];
        end
      end
      OP_ALIGN: begin
        emit    = 1'b1;
        last    = 1'b1;
        done    = 1'b1;
        byte_d  = BYTE_W'({pbits_q, 1'b1} << (3'd7 - pc_q));
        pbits_d = '0;
        pc_d    = '0;
      end
      OP_FLUSH: begin
        done = 1'b1;
        if (pc_q != '0) begin
          emit    = 1'b1;
          last    = 1'b1;
          byte_d  = BYTE_W'({1'b0, pbits_q} << k);
          pbits_d = '0;
          pc_d    = '0;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (done) begin
      started_d = 1'b0;
    end
  end

  assign can_out = !out_valid_q || out_o.ready;
  assign step    = head_valid_i && (!emit || can_out);
  assign pop_o   = step && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      pbits_q     <= '0;
      rem_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        pc_q      <= pc_d;
        pbits_q   <= pbits_d;
        rem_q     <= rem_d;
        started_q <= started_d;
      end
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_byte_q <= byte_d;
      out_last_q <= last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  a_pbits_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, pbits_q} >> pc_q) == 8'd0))
    else $error("pending bits above the bit count");

  a_started_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i && (head_i.op == OP_BITS))
    else $error("word in progress without a bits entry at the head");

  a_started_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (pc_q == 3'd0) && (rem_q >= NBITS_W'(8)))
    else $error("word in progress with too few bits left");

endmodule

`default_nettype wire

[rtl/exp_golomb_bitstream_writer.sv]
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_writer
// Packs raw, ue(v), se(v), alignment and flush elements MSB first into bytes.
//
// in_i carries one syntax element per word: kind, value and bit_count.
// out_o carries one completed byte per word; last marks the final byte that
// an element produced. Elements that complete no byte produce no word.
// Path: an accepted element passes through the front register and the
// queue to the packer, which places its bytes in the output register.
// Throughput: one element per cycle while each completes at most one byte and
// the receiver does not stall; the packer emits one byte per cycle, and an
// element completing n bytes (up to 8 for a long ue/se code) holds the packer until all n are out.
// Reset empties the queue and clears the pending partial byte.
// When the receiver stalls, the output register holds its byte, the packer
// waits, and the queue and front register fill before in_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_bitstream_writer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  egbw_in_if.sink    in_i,
  egbw_out_if.source out_o
);
  import egbw_pkg::*;

  logic        push_valid, push_ready;
  egbw_entry_t push_entry;
  logic        head_valid, pop;
  egbw_entry_t head;

  egbw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  egbw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_entry_o  (head)
  );

  egbw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
